@@ rtl/tsh_pkg.sv @@
// Shared constants, types and helper functions for the two-axis stepper homing block.
// No dependencies; every other file imports this package.
package tsh_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_MAX = 16;

    // Wide enough to compare any sample width against the analog threshold.
    localparam int CMP_W = SAMPLE_BITS_MAX + 1;
    localparam logic [CMP_W-1:0] ANALOG_THRESHOLD = CMP_W'(512);

    localparam int LOG_W  = 3;
    localparam int DIST_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIST_W;

    localparam logic [LOG_W-1:0] FINEST_LOG = 3'd5;
    localparam logic [LOG_W-1:0] FULL_STEP_LOG = 3'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOG        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_MODE    = 2'd2;

    // M0 pin codes.
    localparam logic [1:0] M0_LOW   = 2'd0;
    localparam logic [1:0] M0_HIGH  = 2'd1;
    localparam logic [1:0] M0_FLOAT = 2'd2;

    typedef struct packed {
        logic       tool_step;
        logic       table_step;
        logic       tool_direction;
        logic       table_direction;
        logic       mode_high_pin;
        logic [1:0] mode_low_pin;
        logic [1:0] phase;
        logic       done_res;
    } result_t;

    // Finest microstep log, with codes above five treated as five.
    function automatic logic [LOG_W-1:0] sat_log(input logic [LOG_W-1:0] raw);
        return (raw > FINEST_LOG) ? FINEST_LOG : raw;
    endfunction

    function automatic logic [1:0] m0_code(input logic [LOG_W-1:0] lg);
        logic [1:0] code;
        code = M0_LOW;
        if (lg == 3'd2 || lg == 3'd5)
        begin
            code = M0_FLOAT;
        end
        else if (lg == 3'd1 || lg == 3'd4)
        begin
            code = M0_HIGH;
        end
        return code;
    endfunction

endpackage

@@ rtl/tsh_limit.sv @@
// Limit detector for one axis: either of two samples active makes a hit.
// Depends on tsh_pkg for the analog threshold.
module tsh_limit
    import tsh_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic [SAMPLE_BITS-1:0] sample_a,
    input  logic [SAMPLE_BITS-1:0] sample_b,
    input  logic                   analog,
    output logic                   hit
);

    logic [CMP_W-1:0] ext_a;
    logic [CMP_W-1:0] ext_b;
    logic             act_a;
    logic             act_b;

    assign ext_a = CMP_W'(sample_a);
    assign ext_b = CMP_W'(sample_b);

    // Analog mode compares against the threshold, digital mode takes any nonzero level.
    assign act_a = analog ? (ext_a > ANALOG_THRESHOLD) : (sample_a != '0);
    assign act_b = analog ? (ext_b > ANALOG_THRESHOLD) : (sample_b != '0);
    assign hit   = act_a | act_b;

endmodule

@@ rtl/two_axis_stepper_homing.sv @@
// Top level of the two-axis stepper homing sequencer.
// Depends on tsh_pkg and tsh_limit.
// Path: input register, then result register; the state update sits between the two.
// Throughput: one item per cycle unless out_stall holds back a full result register.
// Reset clears all control state and loads the finest microstep (32).
module two_axis_stepper_homing
    import tsh_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] tool_limit_a,
    input  logic [SAMPLE_BITS-1:0] tool_limit_b,
    input  logic [SAMPLE_BITS-1:0] table_limit_a,
    input  logic [SAMPLE_BITS-1:0] table_limit_b,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   tool_step,
    output logic                   table_step,
    output logic                   tool_direction,
    output logic                   table_direction,
    output logic                   mode_high_pin,
    output logic [1:0]             mode_low_pin,
    output logic [1:0]             phase,
    output logic                   done_res,

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEEK  = 2'd1,
        PH_TOOL  = 2'd2,
        PH_TABLE = 2'd3
    } phase_t;

    // Configuration registers.
    logic [LOG_W-1:0]  max_log_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              analog_reg;

    // Input register.
    logic                   s1_valid_reg;
    logic                   cmd_reg;
    logic [SAMPLE_BITS-1:0] tool_a_reg;
    logic [SAMPLE_BITS-1:0] tool_b_reg;
    logic [SAMPLE_BITS-1:0] table_a_reg;
    logic [SAMPLE_BITS-1:0] table_b_reg;

    // Sequencer state.
    phase_t            phase_reg;
    phase_t            phase_next;
    logic              tool_seek_reg;
    logic              tool_seek_next;
    logic              table_seek_reg;
    logic              table_seek_next;
    logic [DIST_W-1:0] count_reg;
    logic [DIST_W-1:0] count_next;
    logic [LOG_W-1:0]  ml_reg;
    logic [LOG_W-1:0]  ml_next;
    logic              tool_dir_reg;
    logic              tool_dir_next;
    logic              table_dir_reg;
    logic              table_dir_next;

    // Result register.
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;

    logic              s1_go;
    logic              tool_hit;
    logic              table_hit;
    logic [LOG_W-1:0]  finest;
    logic [LOG_W-1:0]  cfg_finest;
    logic              bo_more;
    logic [DIST_W-1:0] bo_count;

    tsh_limit #(.SAMPLE_BITS(SAMPLE_BITS)) u_tool_limit
    (
        .sample_a (tool_a_reg),
        .sample_b (tool_b_reg),
        .analog   (analog_reg),
        .hit      (tool_hit)
    );

    tsh_limit #(.SAMPLE_BITS(SAMPLE_BITS)) u_table_limit
    (
        .sample_a (table_a_reg),
        .sample_b (table_b_reg),
        .analog   (analog_reg),
        .hit      (table_hit)
    );

    // The input register moves on when the result register is empty or being emptied.
    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    assign finest     = sat_log(max_log_reg);
    assign cfg_finest = sat_log(cfg_data[LOG_W-1:0]);

    assign bo_more  = count_reg < dist_reg;
    assign bo_count = bo_more ? count_reg + DIST_W'(1) : count_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        tool_seek_next  = tool_seek_reg;
        table_seek_next = table_seek_reg;
        count_next      = count_reg;
        ml_next         = ml_reg;
        tool_dir_next   = tool_dir_reg;
        table_dir_next  = table_dir_reg;
        res_next        = '0;

        if (cmd_reg)
        begin
            ml_next         = finest;
            table_dir_next  = 1'b0;
            tool_seek_next  = !tool_hit;
            table_seek_next = !table_hit;
            phase_next      = PH_SEEK;
            tool_dir_next   = 1'b0;
            // Both axes already at a limit: go straight to the tool back-off.
            if (tool_hit && table_hit)
            begin
                phase_next    = PH_TOOL;
                count_next    = '0;
                ml_next       = FULL_STEP_LOG;
                tool_dir_next = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    res_next.tool_step  = tool_seek_reg;
                    res_next.table_step = table_seek_reg;
                    tool_seek_next      = !tool_hit;
                    table_seek_next     = !table_hit;
                    if (tool_hit && table_hit)
                    begin
                        phase_next    = PH_TOOL;
                        count_next    = '0;
                        ml_next       = FULL_STEP_LOG;
                        tool_dir_next = !tool_dir_reg;
                    end
                end
                PH_TOOL:
                begin
                    res_next.tool_step = bo_more;
                    count_next         = bo_count;
                    if (bo_count >= dist_reg)
                    begin
                        tool_dir_next  = !tool_dir_reg;
                        table_dir_next = !table_dir_reg;
                        count_next     = '0;
                        phase_next     = PH_TABLE;
                    end
                end
                PH_TABLE:
                begin
                    res_next.table_step = bo_more;
                    count_next          = bo_count;
                    if (bo_count >= dist_reg)
                    begin
                        table_dir_next    = !table_dir_reg;
                        count_next        = '0;
                        ml_next           = finest;
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        res_next.tool_direction  = tool_dir_next;
        res_next.table_direction = table_dir_next;
        res_next.mode_high_pin   = ml_next > 3'd2;
        res_next.mode_low_pin    = m0_code(ml_next);
        res_next.phase           = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_log_reg    <= FINEST_LOG;
            dist_reg       <= '0;
            analog_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            tool_seek_reg  <= 1'b0;
            table_seek_reg <= 1'b0;
            count_reg      <= '0;
            ml_reg         <= FINEST_LOG;
            tool_dir_reg   <= 1'b0;
            table_dir_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                tool_seek_reg  <= tool_seek_next;
                table_seek_reg <= table_seek_next;
                count_reg      <= count_next;
                ml_reg         <= ml_next;
                tool_dir_reg   <= tool_dir_next;
                table_dir_reg  <= table_dir_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MAX_LOG:
                    begin
                        max_log_reg <= cfg_data[LOG_W-1:0];
                        // A lower finest microstep also pulls down the current one.
                        if (ml_reg > cfg_finest)
                        begin
                            ml_reg <= cfg_finest;
                        end
                    end
                    CFG_LIMIT_DISTANCE:
                    begin
                        dist_reg <= cfg_data[DIST_W-1:0];
                    end
                    CFG_ANALOG_MODE:
                    begin
                        analog_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg     <= cmd;
            tool_a_reg  <= tool_limit_a;
            tool_b_reg  <= tool_limit_b;
            table_a_reg <= table_limit_a;
            table_b_reg <= table_limit_b;
        end
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tool_step       = res_reg.tool_step;
    assign table_step      = res_reg.table_step;
    assign tool_direction  = res_reg.tool_direction;
    assign table_direction = res_reg.table_direction;
    assign mode_high_pin   = res_reg.mode_high_pin;
    assign mode_low_pin    = res_reg.mode_low_pin;
    assign phase           = res_reg.phase;
    assign done_res        = res_reg.done_res;

    // The back-off counter is always cleared by the time the sequence is idle.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("back-off count nonzero while idle");

    a_ml_range: assert property (@(posedge clk) disable iff (!rst_n)
        ml_reg <= FINEST_LOG)
        else $error("microstep log above finest");

    // The finishing result always reports the idle phase.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> (res_reg.phase == PH_IDLE))
        else $error("done reported outside idle");

    a_tool_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.tool_step) |-> (res_reg.phase != PH_IDLE))
        else $error("tool step reported with idle phase");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule

@@ verif/homing_checker.sv @@
// Transfer monitor and pin predictor for the two-axis stepper homing sequencer.
// Depends on tsh_pkg; also holds homing_tb_pkg, the command and phase codes that the
// testbench top shares with this checker.
package homing_tb_pkg;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_SEEK,
        PH_TOOL_BACKOFF,
        PH_TABLE_BACKOFF
    } homing_phase_e;

endpackage

module homing_checker
    import tsh_pkg::*;
    import homing_tb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] tool_limit_a,
    input  logic [SAMPLE_BITS-1:0] tool_limit_b,
    input  logic [SAMPLE_BITS-1:0] table_limit_a,
    input  logic [SAMPLE_BITS-1:0] table_limit_b,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   tool_step,
    input  logic                   table_step,
    input  logic                   tool_direction,
    input  logic                   table_direction,
    input  logic                   mode_high_pin,
    input  logic [1:0]             mode_low_pin,
    input  logic [1:0]             phase,
    input  logic                   done_res,

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     mismatches,
    output int                     pending
);

    localparam int MAX_REPORTS = 10;

    // Register copies.
    logic [LOG_W-1:0]  max_log_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              analog_reg;

    // Sequencer state as predicted.
    homing_phase_e     phase_now;
    logic              tool_seek;
    logic              table_seek;
    logic [DIST_W-1:0] steps_backed;
    logic [LOG_W-1:0]  ustep_log;
    logic              tool_dir;
    logic              table_dir;

    result_t           expected_pins[$];
    result_t           seen;
    result_t           want;

    function automatic logic [LOG_W-1:0] finest_log();
        return (max_log_reg > FINEST_LOG) ? FINEST_LOG : max_log_reg;
    endfunction

    function automatic logic limit_hit(input logic [SAMPLE_BITS-1:0] sample);
        if (analog_reg)
        begin
            return CMP_W'(sample) > ANALOG_THRESHOLD;
        end
        return sample != '0;
    endfunction

    function automatic void enter_tool_backoff();
        phase_now    = PH_TOOL_BACKOFF;
        steps_backed = '0;
        ustep_log    = FULL_STEP_LOG;
        tool_dir     = ~tool_dir;
    endfunction

    // Advances the predicted sequencer by one item and returns the pins after it.
    function automatic result_t advance_homing(input logic op,
                                               input logic [SAMPLE_BITS-1:0] tool_a,
                                               input logic [SAMPLE_BITS-1:0] tool_b,
                                               input logic [SAMPLE_BITS-1:0] tab_a,
                                               input logic [SAMPLE_BITS-1:0] tab_b);
        result_t pins;
        logic    tool_hit;
        logic    table_hit;
        pins      = '0;
        tool_hit  = limit_hit(tool_a) || limit_hit(tool_b);
        table_hit = limit_hit(tab_a) || limit_hit(tab_b);

        if (op == CMD_START)
        begin
            ustep_log  = finest_log();
            tool_dir   = 1'b0;
            table_dir  = 1'b0;
            tool_seek  = ~tool_hit;
            table_seek = ~table_hit;
            phase_now  = PH_SEEK;
            if (!tool_seek && !table_seek)
            begin
                enter_tool_backoff();
            end
        end
        else if (phase_now == PH_SEEK)
        begin
            // The step is taken on the tick that finds the limit.
            pins.tool_step  = tool_seek;
            pins.table_step = table_seek;
            tool_seek       = ~tool_hit;
            table_seek      = ~table_hit;
            if (!tool_seek && !table_seek)
            begin
                enter_tool_backoff();
            end
        end
        else if (phase_now == PH_TOOL_BACKOFF)
        begin
            if (steps_backed < distance_reg)
            begin
                pins.tool_step = 1'b1;
                steps_backed   = steps_backed + 1'b1;
            end
            if (steps_backed >= distance_reg)
            begin
                tool_dir     = ~tool_dir;
                table_dir    = ~table_dir;
                steps_backed = '0;
                phase_now    = PH_TABLE_BACKOFF;
            end
        end
        else if (phase_now == PH_TABLE_BACKOFF)
        begin
            if (steps_backed < distance_reg)
            begin
                pins.table_step = 1'b1;
                steps_backed    = steps_backed + 1'b1;
            end
            if (steps_backed >= distance_reg)
            begin
                table_dir     = ~table_dir;
                steps_backed  = '0;
                ustep_log     = finest_log();
                phase_now     = PH_IDLE;
                pins.done_res = 1'b1;
            end
        end

        pins.tool_direction  = tool_dir;
        pins.table_direction = table_dir;
        pins.mode_high_pin   = ustep_log > 3'd2;
        case (ustep_log)
            3'd1, 3'd4: pins.mode_low_pin = M0_HIGH;
            3'd2, 3'd5: pins.mode_low_pin = M0_FLOAT;
            default:    pins.mode_low_pin = M0_LOW;
        endcase
        pins.phase = phase_now;
        return pins;
    endfunction

    task automatic report(input string what, input result_t exp_pins, input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t %s: expected step %0b/%0b dir %0b/%0b m1 %0b m0 %0d phase %0d done %0b",
                     $time, what, exp_pins.tool_step, exp_pins.table_step,
                     exp_pins.tool_direction, exp_pins.table_direction, exp_pins.mode_high_pin,
                     exp_pins.mode_low_pin, exp_pins.phase, exp_pins.done_res);
            $display("    got step %0b/%0b dir %0b/%0b m1 %0b m0 %0d phase %0d done %0b",
                     got.tool_step, got.table_step, got.tool_direction, got.table_direction,
                     got.mode_high_pin, got.mode_low_pin, got.phase, got.done_res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_log_reg  = FINEST_LOG;
            distance_reg = '0;
            analog_reg   = 1'b0;
            phase_now    = PH_IDLE;
            tool_seek    = 1'b0;
            table_seek   = 1'b0;
            steps_backed = '0;
            ustep_log    = FINEST_LOG;
            tool_dir     = 1'b0;
            table_dir    = 1'b0;
            expected_pins.delete();
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_LOG:
                    begin
                        max_log_reg = cfg_data[LOG_W-1:0];
                        // A coarser setting also pulls the present microstep down.
                        if (ustep_log > finest_log())
                        begin
                            ustep_log = finest_log();
                        end
                    end
                    CFG_LIMIT_DISTANCE: distance_reg = cfg_data[DIST_W-1:0];
                    CFG_ANALOG_MODE:    analog_reg = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                expected_pins.push_back(advance_homing(cmd, tool_limit_a, tool_limit_b,
                                                       table_limit_a, table_limit_b));
            end

            if (out_valid && !out_stall)
            begin
                seen = {tool_step, table_step, tool_direction, table_direction,
                        mode_high_pin, mode_low_pin, phase, done_res};
                if (expected_pins.size() == 0)
                begin
                    report("result transfer with nothing expected", '0, seen);
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (seen !== want)
                    begin
                        report("result mismatch", want, seen);
                    end
                end
            end

            pending = expected_pins.size();
        end
    end

endmodule

@@ verif/tb_two_axis_stepper_homing.sv @@
// Testbench top for the two-axis stepper homing sequencer: clock, reset, register writes,
// limit-sample stimulus with sender gaps and receiver stalls, watchdog and verdict.
// Depends on tsh_pkg, homing_tb_pkg, homing_checker and the block itself.
module tb_two_axis_stepper_homing;
    import tsh_pkg::*;
    import homing_tb_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX     = (1 << SB) - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 220;
    localparam int NUM_PHASES     = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [SB-1:0]         tool_limit_a;
    logic [SB-1:0]         tool_limit_b;
    logic [SB-1:0]         table_limit_a;
    logic [SB-1:0]         table_limit_b;
    logic                  out_valid;
    logic                  out_stall;
    logic                  tool_step;
    logic                  table_step;
    logic                  tool_direction;
    logic                  table_direction;
    logic                  mode_high_pin;
    logic [1:0]            mode_low_pin;
    logic [1:0]            phase;
    logic                  done_res;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    pending;

    int                    send_gap_pct;
    int                    stall_pct;
    int                    hold_request;
    int                    holds_served;
    int                    idle_cycles;
    logic                  cur_analog;
    logic [DIST_W-1:0]     cur_dist;

    two_axis_stepper_homing #(.SAMPLE_BITS(SB)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .tool_limit_a   (tool_limit_a),
        .tool_limit_b   (tool_limit_b),
        .table_limit_a  (table_limit_a),
        .table_limit_b  (table_limit_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tool_step      (tool_step),
        .table_step     (table_step),
        .tool_direction (tool_direction),
        .table_direction(table_direction),
        .mode_high_pin  (mode_high_pin),
        .mode_low_pin   (mode_low_pin),
        .phase          (phase),
        .done_res       (done_res),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    homing_checker #(.SAMPLE_BITS(SB)) homing_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .tool_limit_a   (tool_limit_a),
        .tool_limit_b   (tool_limit_b),
        .table_limit_a  (table_limit_a),
        .table_limit_b  (table_limit_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tool_step      (tool_step),
        .table_step     (table_step),
        .tool_direction (tool_direction),
        .table_direction(table_direction),
        .mode_high_pin  (mode_high_pin),
        .mode_low_pin   (mode_low_pin),
        .phase          (phase),
        .done_res       (done_res),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Ends the run when neither channel completes a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : result_side
        holds_served = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != holds_served)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [SB-1:0] tool_a,
                             input logic [SB-1:0] tool_b, input logic [SB-1:0] tab_a,
                             input logic [SB-1:0] tab_b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        tool_limit_a  <= tool_a;
        tool_limit_b  <= tool_b;
        table_limit_a <= tab_a;
        table_limit_b <= tab_b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // A sample that counts as an active limit with the given odds in the present mode.
    function automatic logic [SB-1:0] limit_sample(input int active_pct);
        logic active;
        active = $urandom_range(99) < active_pct;
        if (cur_analog)
        begin
            return active ? SB'($urandom_range(SAMPLE_MAX, 513)) : SB'($urandom_range(512, 0));
        end
        return active ? SB'($urandom_range(SAMPLE_MAX, 1)) : '0;
    endfunction

    // Register writes happen only once every transfer in flight has come out.
    task automatic program_regs(input logic [LOG_W-1:0] lg, input logic [DIST_W-1:0] distance,
                                input logic analog);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_LOG;
        cfg_data  <= CFG_DATA_W'(lg);
        @(posedge clk);
        cfg_index <= CFG_LIMIT_DISTANCE;
        cfg_data  <= CFG_DATA_W'(distance);
        @(posedge clk);
        cfg_index <= CFG_ANALOG_MODE;
        cfg_data  <= CFG_DATA_W'(analog);
        @(posedge clk);
        cfg_write  <= 1'b0;
        cur_dist   = distance;
        cur_analog = analog;
    endtask

    // Mostly complete homing runs with random samples, some cut short by a restart,
    // mixed with a few arbitrary items.
    task automatic run_homing_traffic(input int n_items);
        int sent;
        int tail;
        int seek_pct;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(1'($urandom_range(1)), SB'($urandom), SB'($urandom),
                          SB'($urandom), SB'($urandom));
                sent++;
            end
            else
            begin
                send_item(CMD_START, limit_sample(10), limit_sample(10),
                          limit_sample(10), limit_sample(10));
                sent++;
                tail = $urandom_range(10, 1) + 2 * cur_dist + $urandom_range(3, 0);
                if ($urandom_range(99) < 15)
                begin
                    tail = $urandom_range(tail, 1);
                end
                for (k = 0; k < tail; k++)
                begin
                    // Both axes must find a limit on the same tick to leave seeking.
                    seek_pct = ($urandom_range(3) == 0) ? 60 : 12;
                    send_item(CMD_TICK, limit_sample(seek_pct), limit_sample(seek_pct),
                              limit_sample(seek_pct), limit_sample(seek_pct));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        int k;
        int gap_of[NUM_PHASES];
        int stall_of[NUM_PHASES];
        logic [LOG_W-1:0] log_of[NUM_PHASES];
        logic [DIST_W-1:0] dist_of[NUM_PHASES];
        logic analog_of[NUM_PHASES];

        gap_of    = '{0, 81, 0, 33, 0, 0};
        stall_of  = '{0, 0, 81, 33, 0, 0};
        log_of    = '{3'd5, 3'd3, 3'd1, 3'd6, 3'd2, 3'd4};
        dist_of   = '{15'd0, 15'd4, 15'd2, 15'd5, 15'd1, 15'd32767};
        analog_of = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        send_gap_pct = 0;
        stall_pct    = 0;
        hold_request = 0;
        cur_analog   = 1'b0;
        cur_dist     = '0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_TICK;
        tool_limit_a  <= '0;
        tool_limit_b  <= '0;
        table_limit_a <= '0;
        table_limit_b <= '0;
        cfg_write     <= 1'b0;
        cfg_index     <= CFG_MAX_LOG;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Analog limits around the threshold, saturated microstep setting, short back-off.
        program_regs(3'd7, 15'd2, 1'b1);
        send_item(CMD_TICK, SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX));
        send_item(CMD_START, '0, '0, '0, '0);
        send_item(CMD_TICK, SB'(512), '0, '0, SB'(513));
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_TICK, '0, SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), '0);
        for (k = 0; k < 5; k++)
        begin
            send_item(CMD_TICK, SB'(10'h2AA), SB'(10'h155), SB'(10'h155), SB'(10'h2AA));
        end
        // Limits already active at start, then a restart while backing off.
        send_item(CMD_START, SB'(SAMPLE_MAX), '0, '0, SB'(SAMPLE_MAX));
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_START, '0, '0, '0, '0);
        send_item(CMD_TICK, SB'(513), SB'(513), SB'(513), SB'(513));
        for (k = 0; k < 4; k++)
        begin
            send_item(CMD_TICK, '0, '0, '0, '0);
        end

        // Digital limits, full step only, zero back-off distance.
        program_regs(3'd0, 15'd0, 1'b0);
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_START, SB'(1), '0, '0, '0);
        send_item(CMD_TICK, '0, '0, '0, SB'(1));
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_START, '0, '0, '0, '0);
        send_item(CMD_TICK, SB'(SAMPLE_MAX), '0, SB'(1), '0);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            send_gap_pct = gap_of[p];
            stall_pct    = stall_of[p];
            program_regs(log_of[p], dist_of[p], analog_of[p]);
            if (p == 4)
            begin
                hold_request++;
            end
            // An idle tick first shows the pins right after the register change.
            send_item(CMD_TICK, '0, '0, '0, '0);
            if (dist_of[p] == {DIST_W{1'b1}})
            begin
                // A long stretch of the longest tool back-off; the run ends inside it.
                send_item(CMD_START, SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX),
                          SB'(SAMPLE_MAX));
                for (k = 0; k < PHASE_ITEMS - 1; k++)
                begin
                    send_item(CMD_TICK, SB'($urandom), SB'($urandom), SB'($urandom),
                              SB'($urandom));
                end
            end
            else
            begin
                run_homing_traffic(PHASE_ITEMS);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
